// ===== hw/rtl/fqrbv_pkg.sv =====
// shared types and constants of the fifo queue with remove by value
package fqrbv_pkg;

    localparam int WORD_W = 32;
    localparam int OP_W   = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_REMOVE
    } t_state;

    // per-cycle command to the row of cells
    typedef struct packed {
        logic shift;  // every cell below the top takes its upper neighbour
        logic load;   // the addressed cell takes the write word
    } t_cell_ctl;

endpackage

// ===== hw/rtl/fifo_queue_with_remove_by_value_core.sv =====
// top level: fifo queue of words with remove by value, built as a shifting row of cells
// push, pop, unknown codes: result registered in the cycle after the beat is accepted
// remove: the row shifts one entry per cycle past the head comparator
// one operation in flight at a time; a new beat is taken as the previous result leaves
// reset (synchronous, active low) empties the queue; cell contents are not cleared
module fifo_queue_with_remove_by_value_core #(
    parameter int QUEUE_DEPTH = 16,
    localparam int CW      = $clog2(QUEUE_DEPTH + 1),
    localparam int IW      = $clog2(QUEUE_DEPTH),
    localparam int PACK_W  = 1 + fqrbv_pkg::WORD_W + 1 + CW + 2,
    localparam int OUT_W   = ((PACK_W + 7) / 8) * 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [fqrbv_pkg::WORD_W-1:0]     i_s_tdata,  // data_in
    input  logic [fqrbv_pkg::OP_W-1:0]       i_s_tuser,  // operation
    // result channel
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [OUT_W-1:0]                 o_m_tdata   // success, data_out, hit, count,
                                                          // empty_res, full_res, zero pad
);

    // cell row: index 0 holds the oldest entry
    logic [fqrbv_pkg::WORD_W-1:0] w_cell [QUEUE_DEPTH];
    fqrbv_pkg::t_cell_ctl         w_ctl;
    logic [IW-1:0]                w_target;
    logic [fqrbv_pkg::WORD_W-1:0] w_cell_word;

    // result fields
    logic                         w_success;
    logic [fqrbv_pkg::WORD_W-1:0] w_data;
    logic                         w_hit;
    logic [CW-1:0]                w_count;
    logic                         w_empty;
    logic                         w_full;

    fqrbv_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CW          (CW),
        .IW          (IW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_op        (i_s_tuser),
        .i_word      (i_s_tdata),
        .i_head      (w_cell[0]),
        .o_ctl       (w_ctl),
        .o_target    (w_target),
        .o_cell_word (w_cell_word),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_success   (w_success),
        .o_data      (w_data),
        .o_hit       (w_hit),
        .o_count     (w_count),
        .o_empty     (w_empty),
        .o_full      (w_full)
    );

    // each cell takes its upper neighbour on a shift; the top cell keeps its own word
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic [fqrbv_pkg::WORD_W-1:0] w_next;
        if (g == QUEUE_DEPTH - 1) begin : g_top
            assign w_next = w_cell[g];
        end else begin : g_mid
            assign w_next = w_cell[g + 1];
        end

        fqrbv_cell #(
            .IDX (g),
            .IW  (IW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_target (w_target),
            .i_word   (w_cell_word),
            .i_next   (w_next),
            .o_data   (w_cell[g])
        );
    end

    // result beat packing: success in the lowest bit, zero pad at the top
    assign o_m_tdata = {{(OUT_W - PACK_W){1'b0}},
                        w_full, w_empty, w_count, w_hit, w_data, w_success};

endmodule

// ===== hw/rtl/fqrbv_cell.sv =====
// one storage cell of the queue row
module fqrbv_cell #(
    parameter int IDX = 0,
    parameter int IW  = 4
) (
    input  logic                            i_clk,
    input  fqrbv_pkg::t_cell_ctl            i_ctl,
    input  logic [IW-1:0]                   i_target,
    input  logic [fqrbv_pkg::WORD_W-1:0]    i_word,
    input  logic [fqrbv_pkg::WORD_W-1:0]    i_next,
    output logic [fqrbv_pkg::WORD_W-1:0]    o_data
);

    logic [fqrbv_pkg::WORD_W-1:0] r_data;
    logic [fqrbv_pkg::WORD_W-1:0] n_data;
    logic                         w_sel;

    assign w_sel = i_ctl.load && (i_target == IW'(IDX));

    always_comb begin
        if (w_sel) begin
            n_data = i_word;
        end else if (i_ctl.shift) begin
            n_data = i_next;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== hw/rtl/fqrbv_ctrl.sv =====
// queue control: occupancy, remove sequencer and registered result
module fqrbv_ctrl #(
    parameter int QUEUE_DEPTH = 16,
    parameter int CW          = 5,
    parameter int IW          = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [fqrbv_pkg::OP_W-1:0]      i_op,
    input  logic [fqrbv_pkg::WORD_W-1:0]    i_word,
    input  logic [fqrbv_pkg::WORD_W-1:0]    i_head,
    output fqrbv_pkg::t_cell_ctl            o_ctl,
    output logic [IW-1:0]                   o_target,
    output logic [fqrbv_pkg::WORD_W-1:0]    o_cell_word,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_success,
    output logic [fqrbv_pkg::WORD_W-1:0]    o_data,
    output logic                            o_hit,
    output logic [CW-1:0]                   o_count,
    output logic                            o_empty,
    output logic                            o_full
);

    fqrbv_pkg::t_state r_state, n_state;
    logic [CW-1:0]                r_count, n_count;
    logic [CW-1:0]                r_left, n_left;
    logic                         r_hit, n_hit;
    logic [fqrbv_pkg::WORD_W-1:0] r_value, n_value;
    logic                         r_out_valid, n_out_valid;
    logic                         r_out_success, n_out_success;
    logic [fqrbv_pkg::WORD_W-1:0] r_out_data, n_out_data;
    logic                         r_out_hit, n_out_hit;
    logic [CW-1:0]                r_out_count;
    logic                         r_out_empty, r_out_full;

    logic          w_accept;
    logic          w_keep;
    logic          w_last;
    logic          w_load_out;
    logic [CW-1:0] w_count_dec;

    assign o_ready     = (r_state == fqrbv_pkg::ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept    = i_valid && o_ready;
    assign w_keep      = (i_head != r_value);
    assign w_last      = (r_left == CW'(1));
    assign w_count_dec = r_count - CW'(1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fqrbv_pkg::ST_IDLE: begin
                if (w_accept && i_op == fqrbv_pkg::OP_REMOVE && r_count != '0) begin
                    n_state = fqrbv_pkg::ST_REMOVE;
                end
            end
            fqrbv_pkg::ST_REMOVE: begin
                if (w_last) begin
                    n_state = fqrbv_pkg::ST_IDLE;
                end
            end
            default: n_state = fqrbv_pkg::ST_IDLE;
        endcase
    end

    // cell row commands
    always_comb begin
        o_ctl       = '0;
        o_target    = r_count[IW-1:0];
        o_cell_word = i_word;
        case (r_state)
            fqrbv_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (i_op)
                        fqrbv_pkg::OP_PUSH: begin
                            o_ctl.load = (r_count < CW'(QUEUE_DEPTH));
                        end
                        fqrbv_pkg::OP_POP: begin
                            o_ctl.shift = (r_count != '0);
                        end
                        default: ;
                    endcase
                end
            end
            fqrbv_pkg::ST_REMOVE: begin
                // head leaves the row; a survivor goes back in at the new tail
                o_ctl.shift = 1'b1;
                o_ctl.load  = w_keep;
                o_target    = w_count_dec[IW-1:0];
                o_cell_word = i_head;
            end
            default: ;
        endcase
    end

    // occupancy, sequencer and result registers
    always_comb begin
        n_count       = r_count;
        n_left        = r_left;
        n_hit         = r_hit;
        n_value       = r_value;
        w_load_out    = 1'b0;
        n_out_success = 1'b0;
        n_out_data    = '0;
        n_out_hit     = 1'b0;
        case (r_state)
            fqrbv_pkg::ST_IDLE: begin
                if (w_accept) begin
                    w_load_out = 1'b1;
                    case (i_op)
                        fqrbv_pkg::OP_PUSH: begin
                            if (r_count < CW'(QUEUE_DEPTH)) begin
                                n_count       = r_count + CW'(1);
                                n_out_success = 1'b1;
                            end
                        end
                        fqrbv_pkg::OP_POP: begin
                            if (r_count != '0) begin
                                n_count       = w_count_dec;
                                n_out_success = 1'b1;
                                n_out_data    = i_head;
                            end
                        end
                        fqrbv_pkg::OP_REMOVE: begin
                            if (r_count != '0) begin
                                w_load_out = 1'b0;
                                n_left     = r_count;
                                n_hit      = 1'b0;
                                n_value    = i_word;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            fqrbv_pkg::ST_REMOVE: begin
                n_left = r_left - CW'(1);
                if (!w_keep) begin
                    n_count = w_count_dec;
                    n_hit   = 1'b1;
                end
                if (w_last) begin
                    w_load_out = 1'b1;
                    n_out_hit  = r_hit || !w_keep;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fqrbv_pkg::ST_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (w_load_out) begin
            r_out_success <= n_out_success;
            r_out_data    <= n_out_data;
            r_out_hit     <= n_out_hit;
            r_out_count   <= n_count;
            r_out_empty   <= (n_count == '0);
            r_out_full    <= (n_count == CW'(QUEUE_DEPTH));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_success   = r_out_success;
    assign o_data      = r_out_data;
    assign o_hit       = r_out_hit;
    assign o_count     = r_out_count;
    assign o_empty     = r_out_empty;
    assign o_full      = r_out_full;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    a_remove_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == fqrbv_pkg::ST_REMOVE |-> !r_out_valid)
        else $error("result pending while remove is running");

    a_remove_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == fqrbv_pkg::ST_REMOVE |-> (r_left != '0 && r_left <= r_count))
        else $error("remove visit count out of range");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_empty == (r_out_count == '0)))
        else $error("empty flag disagrees with count");
`endif

endmodule
